### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the RTL files; compiled away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AST_CHECK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define AST_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define AST_CHECK(lbl, clk, rst, prop, msg)
`define AST_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

### src/ipv6fmt_pkg.sv
// ----------------------------------------------------------------------------
// ipv6fmt_pkg
// Types, character codes and command codes of the IPv6 text formatter.
// ----------------------------------------------------------------------------
package ipv6fmt_pkg;

  typedef struct packed {
    logic [63:0] address_high;
    logic [63:0] address_low;
    logic [31:0] zone_id;
  } item_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic       last_char;
  } result_t;

  // Commands from the controller to the datapath.
  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_SCAN, OP_PFX, OP_BLOAD, OP_BCD, OP_BDIG,
    OP_GRP, OP_HEX, OP_COL2, OP_PCT, OP_FLUSH
  } op_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic mapped;
    logic pfx_done;
    logic bcd_done;
    logic dig_last;
    logic byte_last;
    logic compress;
    logic grp_done;
    logic hex_last;
    logic zone_nz;
  } status_t;

  localparam logic [6:0] CH_ZERO    = 7'h30;
  localparam logic [6:0] CH_COLON   = 7'h3a;
  localparam logic [6:0] CH_DOT     = 7'h2e;
  localparam logic [6:0] CH_PERCENT = 7'h25;
  localparam logic [6:0] CH_F       = 7'h66;

  // Characters of the mapped prefix "::ffff:".
  function automatic logic [6:0] pfx_char(input logic [2:0] idx);
    logic [6:0] c;
    c = CH_F;
    if (idx == 3'd0 || idx == 3'd1 || idx == 3'd6) begin
      c = CH_COLON;
    end
    return c;
  endfunction

  // Lowercase hex digit.
  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    logic [6:0] c;
    if (nib < 4'd10) begin
      c = CH_ZERO + {3'b000, nib};
    end else begin
      c = 7'h57 + {3'b000, nib};
    end
    return c;
  endfunction

endpackage

### src/ipv6fmt_ctrl.sv
// ----------------------------------------------------------------------------
// ipv6fmt_ctrl
// Sequencer of the formatter: walks scan, text and zone phases.
// ----------------------------------------------------------------------------
module ipv6fmt_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  ipv6fmt_pkg::status_t  st,
  output ipv6fmt_pkg::op_t      op,
  output logic                  busy
);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_SCAN  = 13'b0000000000010,
    S_PFX   = 13'b0000000000100,
    S_BLOAD = 13'b0000000001000,
    S_BCONV = 13'b0000000010000,
    S_BDIG  = 13'b0000000100000,
    S_GRP   = 13'b0000001000000,
    S_HEX   = 13'b0000010000000,
    S_COL2  = 13'b0000100000000,
    S_ZONE  = 13'b0001000000000,
    S_ZCONV = 13'b0010000000000,
    S_ZDIG  = 13'b0100000000000,
    S_FLUSH = 13'b1000000000000
  } state_t;

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_next = state;
    op         = ipv6fmt_pkg::OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          op         = ipv6fmt_pkg::OP_LOAD;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        op = ipv6fmt_pkg::OP_SCAN;
        if (st.scan_done) begin
          state_next = st.mapped ? S_PFX : S_GRP;
        end
      end
      S_PFX: begin
        op = ipv6fmt_pkg::OP_PFX;
        if (st.pfx_done) begin
          state_next = S_BLOAD;
        end
      end
      S_BLOAD: begin
        op         = ipv6fmt_pkg::OP_BLOAD;
        state_next = S_BCONV;
      end
      S_BCONV: begin
        op = ipv6fmt_pkg::OP_BCD;
        if (st.bcd_done) begin
          state_next = S_BDIG;
        end
      end
      S_BDIG: begin
        op = ipv6fmt_pkg::OP_BDIG;
        if (st.dig_last) begin
          state_next = st.byte_last ? S_ZONE : S_BLOAD;
        end
      end
      S_GRP: begin
        if (st.grp_done) begin
          state_next = S_ZONE;
        end else begin
          op         = ipv6fmt_pkg::OP_GRP;
          state_next = st.compress ? S_COL2 : S_HEX;
        end
      end
      S_HEX: begin
        op = ipv6fmt_pkg::OP_HEX;
        if (st.hex_last) begin
          state_next = S_GRP;
        end
      end
      S_COL2: begin
        op         = ipv6fmt_pkg::OP_COL2;
        state_next = S_GRP;
      end
      S_ZONE: begin
        if (st.zone_nz) begin
          op         = ipv6fmt_pkg::OP_PCT;
          state_next = S_ZCONV;
        end else begin
          state_next = S_FLUSH;
        end
      end
      S_ZCONV: begin
        op = ipv6fmt_pkg::OP_BCD;
        if (st.bcd_done) begin
          state_next = S_ZDIG;
        end
      end
      S_ZDIG: begin
        op = ipv6fmt_pkg::OP_BDIG;
        if (st.dig_last) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        op         = ipv6fmt_pkg::OP_FLUSH;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

### src/ipv6fmt_dp.sv
// ----------------------------------------------------------------------------
// ipv6fmt_dp
// Datapath: zero-run scan, hex and decimal digit units, output stage.
// ----------------------------------------------------------------------------
module ipv6fmt_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  ipv6fmt_pkg::item_t    item,
  input  ipv6fmt_pkg::op_t      op,
  output ipv6fmt_pkg::status_t  st,
  output logic                  strobe,
  output ipv6fmt_pkg::result_t  result
);

  logic [127:0] addr;
  logic [31:0]  zone;
  logic [3:0]   gi;
  logic [3:0]   cur_len;
  logic [3:0]   best_len;
  logic [2:0]   best_start;
  logic [2:0]   pi;
  logic [1:0]   bi;
  logic [31:0]  bin;
  logic [39:0]  bcd;
  logic [5:0]   bcnt;
  logic [3:0]   di;
  logic         started;
  logic         first;
  logic [1:0]   ni;
  logic [6:0]   pend;
  logic         pend_v;

  logic [15:0]  grp_arr [8];
  logic [7:0]   byte_arr [4];
  logic [3:0]   dig_arr [10];
  logic [39:0]  bcd_adj;
  logic [15:0]  grp;
  logic [7:0]   cur_byte;
  logic [3:0]   dig;
  logic [3:0]   nib;
  logic [1:0]   top_nib;
  logic [3:0]   len_inc;
  logic         emit;
  logic [6:0]   ch;

  // Field views of the stored address and BCD value.
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      grp_arr[k] = addr[127 - 16 * k -: 16];
    end
    for (int k = 0; k < 4; k++) begin
      byte_arr[k] = addr[31 - 8 * k -: 8];
    end
    for (int k = 0; k < 10; k++) begin
      dig_arr[k] = bcd[4 * k +: 4];
      bcd_adj[4 * k +: 4] = (dig_arr[k] >= 4'd5) ? dig_arr[k] + 4'd3 : dig_arr[k];
    end
  end

  assign grp      = grp_arr[gi[2:0]];
  assign cur_byte = byte_arr[bi];
  assign dig      = dig_arr[di];
  assign nib      = grp[4 * ni +: 4];
  assign len_inc  = cur_len + 4'd1;

  // Highest nonzero nibble of the current group; zero groups print one digit.
  always_comb begin
    if (grp[15:12] != 4'd0) begin
      top_nib = 2'd3;
    end else if (grp[11:8] != 4'd0) begin
      top_nib = 2'd2;
    end else if (grp[7:4] != 4'd0) begin
      top_nib = 2'd1;
    end else begin
      top_nib = 2'd0;
    end
  end

  // Status toward the controller.
  always_comb begin
    st.scan_done = (gi[2:0] == 3'd7);
    st.mapped    = (addr[127:48] == 80'd0) && (addr[47:32] == 16'hffff);
    st.pfx_done  = (pi == 3'd6);
    st.bcd_done  = (bcnt == 6'd1);
    st.dig_last  = (di == 4'd0);
    st.byte_last = (bi == 2'd3);
    st.compress  = !gi[3] && (best_len >= 4'd2) && (gi[2:0] == best_start);
    st.grp_done  = gi[3];
    st.hex_last  = (ni == 2'd0);
    st.zone_nz   = (zone != 32'd0);
  end

  // Character produced by the current command.
  always_comb begin
    emit = 1'b0;
    ch   = ipv6fmt_pkg::CH_COLON;
    case (op)
      ipv6fmt_pkg::OP_PFX: begin
        emit = 1'b1;
        ch   = ipv6fmt_pkg::pfx_char(pi);
      end
      ipv6fmt_pkg::OP_BLOAD: begin
        emit = (bi != 2'd0);
        ch   = ipv6fmt_pkg::CH_DOT;
      end
      ipv6fmt_pkg::OP_BDIG: begin
        emit = started || (dig != 4'd0) || (di == 4'd0);
        ch   = ipv6fmt_pkg::CH_ZERO + {3'b000, dig};
      end
      ipv6fmt_pkg::OP_GRP: begin
        emit = st.compress || !first;
      end
      ipv6fmt_pkg::OP_HEX: begin
        emit = 1'b1;
        ch   = ipv6fmt_pkg::hex_char(nib);
      end
      ipv6fmt_pkg::OP_COL2: begin
        emit = 1'b1;
      end
      ipv6fmt_pkg::OP_PCT: begin
        emit = 1'b1;
        ch   = ipv6fmt_pkg::CH_PERCENT;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Working registers, updated per command.
  always_ff @(posedge clk) begin
    case (op)
      ipv6fmt_pkg::OP_LOAD: begin
        addr       <= {item.address_high, item.address_low};
        zone       <= item.zone_id;
        gi         <= 4'd0;
        cur_len    <= 4'd0;
        best_len   <= 4'd0;
        best_start <= 3'd0;
        pi         <= 3'd0;
        bi         <= 2'd0;
        first      <= 1'b1;
      end
      ipv6fmt_pkg::OP_SCAN: begin
        // Strict compare keeps the earliest of equal-length runs.
        if (grp == 16'd0) begin
          cur_len <= len_inc;
          if (len_inc > best_len) begin
            best_len   <= len_inc;
            best_start <= gi[2:0] - cur_len[2:0];
          end
        end else begin
          cur_len <= 4'd0;
        end
        gi <= st.scan_done ? 4'd0 : gi + 4'd1;
      end
      ipv6fmt_pkg::OP_PFX: begin
        pi <= pi + 3'd1;
      end
      ipv6fmt_pkg::OP_BLOAD: begin
        bin     <= {cur_byte, 24'd0};
        bcnt    <= 6'd8;
        bcd     <= 40'd0;
        di      <= 4'd9;
        started <= 1'b0;
      end
      ipv6fmt_pkg::OP_PCT: begin
        bin     <= zone;
        bcnt    <= 6'd32;
        bcd     <= 40'd0;
        di      <= 4'd9;
        started <= 1'b0;
      end
      ipv6fmt_pkg::OP_BCD: begin
        // One double-dabble step: adjust digits, then shift in one bit.
        bcd  <= {bcd_adj[38:0], bin[31]};
        bin  <= {bin[30:0], 1'b0};
        bcnt <= bcnt - 6'd1;
      end
      ipv6fmt_pkg::OP_BDIG: begin
        if (emit) begin
          started <= 1'b1;
        end
        di <= di - 4'd1;
        if (di == 4'd0) begin
          bi <= bi + 2'd1;
        end
      end
      ipv6fmt_pkg::OP_GRP: begin
        ni <= top_nib;
        if (!st.compress) begin
          first <= 1'b0;
        end
      end
      ipv6fmt_pkg::OP_HEX: begin
        ni <= ni - 2'd1;
        if (ni == 2'd0) begin
          gi <= gi + 4'd1;
        end
      end
      ipv6fmt_pkg::OP_COL2: begin
        gi    <= gi + best_len;
        first <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Output stage: one character is held back so the last can be flagged.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
      pend_v <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (op == ipv6fmt_pkg::OP_LOAD) begin
        pend_v <= 1'b0;
      end else if (op == ipv6fmt_pkg::OP_FLUSH) begin
        strobe <= pend_v;
        pend_v <= 1'b0;
      end else if (emit) begin
        strobe <= pend_v;
        pend_v <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op == ipv6fmt_pkg::OP_FLUSH) begin
      result <= '{char_code: pend, last_char: 1'b1};
    end else if (emit) begin
      result <= '{char_code: pend, last_char: 1'b0};
      pend   <= ch;
    end
  end

endmodule

### src/ipv6_address_text_formatter.sv
// ----------------------------------------------------------------------------
// ipv6_address_text_formatter
// Turns one IPv6 address and zone number into its text, one char at a time.
// ----------------------------------------------------------------------------
// Usage: drive item and raise start; the transfer happens at the clock edge
// where start is high and busy is low. Each character appears on result for
// one cycle with strobe high; last_char marks the final one. The receiver
// cannot stall, so the block never waits on the output side.
// Sequence: the transfer cycle and a zero-run scan over the eight groups,
// then the text. Characters leave one emit behind, so the last one is
// sent in the cycle after a final flush cycle. Each hex group starts with
// a decision state; each decimal number runs the bit-serial BCD converter
// (one step per bit: 8 bits per byte, 32 for the zone) and then walks its
// ten BCD digits; a nonzero zone adds a percent sign and its digits.
// busy falls while the last character is on result, and the next transfer
// can happen at the edge that ends that cycle.
// Reset: synchronous, returns the sequencer to idle and drops strobe.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ipv6_address_text_formatter (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  ipv6fmt_pkg::item_t    item,
  output logic                  busy,
  output logic                  strobe,
  output ipv6fmt_pkg::result_t  result
);

  ipv6fmt_pkg::op_t     op;
  ipv6fmt_pkg::status_t st;

  // Sequencer.
  ipv6fmt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .st    (st),
    .op    (op),
    .busy  (busy)
  );

  // Datapath.
  ipv6fmt_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .op     (op),
    .st     (st),
    .strobe (strobe),
    .result (result)
  );

  // The final character ends the job.
  `AST_CHECK(a_last_idle, clk, rst, (strobe && result.last_char) |-> !busy, "busy after last char")
  // An accepted address starts work.
  `AST_CHECK(a_start_busy, clk, rst, (start && !busy) |=> busy, "accept without busy")
  // While idle only a final character may be shown.
  `AST_NEVER(a_idle_strobe, clk, rst, !busy && strobe && !result.last_char, "stray char when idle")

endmodule
